@@ src/ptw_pkg.sv @@
`timescale 1ns / 1ps
package ptw_pkg;

    // fixed-point widths
    localparam int ANG_W   = 21;   // signed angle into the sine unit
    localparam int P_W     = 19;   // signed Q3.16 plane coordinate
    localparam int TRIG_W  = 19;   // signed sine/cosine result, Q3.16

    // sine unit and square-root pipeline depths
    localparam int SIN_LAT      = 16;
    localparam int QSQ_STEPS    = 19;
    localparam int HORNER_STEPS = 3;

    // angle constants in Q16 radians
    localparam logic [18:0] TWO_PI_Q16  = 19'd411775;
    localparam logic [16:0] HALF_PI_Q16 = 17'd102944;
    localparam logic [18:0] QUAD1_Q16   = 19'd102944;
    localparam logic [18:0] QUAD2_Q16   = 19'd205888;
    localparam logic [18:0] QUAD3_Q16   = 19'd308832;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // first taylor divisor and its 2^32 reciprocal
    localparam logic [6:0]  DIV_FIRST   = 7'd72;
    localparam logic [31:0] RECIP_FIRST = 32'd59652323;

    // register indexes of the configuration port
    localparam logic [1:0] REG_OFFSET_X    = 2'd0;
    localparam logic [1:0] REG_OFFSET_Y    = 2'd1;
    localparam logic [1:0] REG_FRAME_PHASE = 2'd2;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_PIXEL = 1'b1;

    typedef struct packed {
        logic        kind;
        logic [15:0] addr;
        logic [31:0] texel;
    } t_tag;

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic        neg;
    } t_sin_carry;

    function automatic logic [6:0] horner_div(input int k);
        logic [6:0] d;
        case (k)
            0:       d = 7'd42;
            1:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] horner_recip(input int k);
        logic [31:0] m;
        case (k)
            0:       m = 32'd102261126;
            1:       m = 32'd214748364;
            default: m = 32'd715827882;
        endcase
        return m;
    endfunction

endpackage

@@ src/planar_texture_warp.sv @@
`timescale 1ns / 1ps
// planar texture warp: a stream of items, each either a texture write (tuser = 0) that stores
// one argb word, or a pixel request (tuser = 1) that maps the screen position to a warped
// texture coordinate and returns the texel found there. one transaction is taken every clock
// unless the output buffer is full. the datapath is a 19-stage square-root pipeline and two
// rounds of 16-stage taylor sine units, ahead of a single-port 64k x 32 texture memory. writes
// travel the same pipeline and reach the memory in input order, so a pixel always sees exactly
// the writes accepted before it. a two-entry output buffer lets the block keep accepting while
// a result waits. the texture is not cleared at reset; it holds garbage until written. offsets
// and phase are to be written through the configuration port only while the block is idle;
// the block itself does not enforce this.
module planar_texture_warp import ptw_pkg::*; #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240,
    parameter int TEX_WIDTH     = 256,
    parameter int TEX_HEIGHT    = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // pixel_x[8:0], pixel_y[16:9], tex_addr[32:17],
                                        // texel[64:33], zero pad
    input  logic        s_axis_tuser,   // kind
    // master stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // color
    // configuration
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    // screen mapping: floor(x * 2^17 / W) by reciprocal and one correction
    localparam int          RECIP_SHIFT = 10;
    localparam logic [23:0] RECIP_X = 24'((64'd1 << (17 + RECIP_SHIFT)) / SCREEN_WIDTH);
    localparam logic [23:0] RECIP_Y = 24'((64'd1 << (17 + RECIP_SHIFT)) / SCREEN_HEIGHT);
    localparam logic [12:0] SW = 13'(SCREEN_WIDTH);
    localparam logic [12:0] SH = 13'(SCREEN_HEIGHT);
    localparam logic [9:0]  TSCALE_X = 10'(TEX_WIDTH - 1);
    localparam logic [9:0]  TSCALE_Y = 10'(TEX_HEIGHT - 1);
    localparam logic [18:0] TEX_W19  = 19'(TEX_WIDTH);

    // pipeline depth up to the memory stage
    localparam int PXY_DLY   = 2 + QSQ_STEPS + SIN_LAT;
    localparam int TAG_DEPTH = 6 + QSQ_STEPS + SIN_LAT + 2 + SIN_LAT + 5;

    localparam logic [1:0] OB_FULL = 2'd2;

    function automatic logic signed [P_W-1:0] sat_p(input logic signed [39:0] v);
        logic signed [P_W-1:0] res;
        if (v > 40'sd262143) begin
            res = 19'sh3FFFF;
        end else if (v < -40'sd262144) begin
            res = 19'sh40000;
        end else begin
            res = v[P_W-1:0];
        end
        return res;
    endfunction

    // configuration registers
    logic signed [15:0] r_off_x;
    logic signed [15:0] r_off_y;
    logic [31:0]        r_phase;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_x <= '0;
            r_off_y <= '0;
            r_phase <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_OFFSET_X:    r_off_x <= i_cfg_data[15:0];
                REG_OFFSET_Y:    r_off_y <= i_cfg_data[15:0];
                REG_FRAME_PHASE: r_phase <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // global advance: the whole pipeline moves unless the output buffer is full
    logic [1:0] r_ob_cnt;
    logic       w_en;
    logic       w_take;

    assign w_en          = (r_ob_cnt != OB_FULL);
    assign s_axis_tready = w_en;
    assign w_take        = s_axis_tvalid & w_en;

    logic [8:0]  w_in_x;
    logic [7:0]  w_in_y;
    t_tag        w_in_tag;

    assign w_in_x         = s_axis_tdata[8:0];
    assign w_in_y         = s_axis_tdata[16:9];
    assign w_in_tag.kind  = s_axis_tuser;
    assign w_in_tag.addr  = s_axis_tdata[32:17];
    assign w_in_tag.texel = s_axis_tdata[64:33];

    // transaction tags ride alongside the datapath
    logic r_vld [TAG_DEPTH];
    t_tag r_tag [TAG_DEPTH];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < TAG_DEPTH; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= w_take;
            for (int i = 1; i < TAG_DEPTH; i++) begin
                r_vld[i] <= r_vld[i-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_tag[0] <= w_in_tag;
            for (int i = 1; i < TAG_DEPTH; i++) begin
                r_tag[i] <= r_tag[i-1];
            end
        end
    end

    // stages 1-4: screen to plane
    logic [8:0]  r_a1_x;
    logic [7:0]  r_a1_y;
    logic [32:0] r_a1_mx;
    logic [32:0] r_a1_my;
    logic [8:0]  r_a2_x;
    logic [7:0]  r_a2_y;
    logic [22:0] r_a2_q0x;
    logic [22:0] r_a2_q0y;
    logic [22:0] r_a3_qx;
    logic [22:0] r_a3_qy;
    logic signed [P_W-1:0] r_a4_px;
    logic signed [P_W-1:0] r_a4_py;
    logic [35:0] w_remx;
    logic [35:0] w_remy;

    assign w_remx = {10'd0, r_a2_x, 17'd0} - 36'(r_a2_q0x) * 36'(SW);
    assign w_remy = {11'd0, r_a2_y, 17'd0} - 36'(r_a2_q0y) * 36'(SH);

    // stages 5-6: squared radius
    logic [18:0] w_ax;
    logic [18:0] w_ay;
    logic [37:0] r_a5_sx;
    logic [37:0] r_a5_sy;
    logic [37:0] r_a6_n;

    assign w_ax = r_a4_px[P_W-1] ? 19'(-r_a4_px) : 19'(r_a4_px);
    assign w_ay = r_a4_py[P_W-1] ? 19'(-r_a4_py) : 19'(r_a4_py);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_a1_x   <= w_in_x;
            r_a1_y   <= w_in_y;
            r_a1_mx  <= 33'(w_in_x) * 33'(RECIP_X);
            r_a1_my  <= 33'(w_in_y) * 33'(RECIP_Y);
            r_a2_x   <= r_a1_x;
            r_a2_y   <= r_a1_y;
            r_a2_q0x <= r_a1_mx[32:RECIP_SHIFT];
            r_a2_q0y <= r_a1_my[32:RECIP_SHIFT];
            r_a3_qx  <= r_a2_q0x + 23'(w_remx >= 36'(SW));
            r_a3_qy  <= r_a2_q0y + 23'(w_remy >= 36'(SH));
            r_a4_px  <= sat_p(40'($signed({1'b0, r_a3_qx})) + 40'(r_off_x) - 40'sd65536);
            r_a4_py  <= sat_p(40'($signed({1'b0, r_a3_qy})) + 40'(r_off_y) - 40'sd65536);
            r_a5_sx  <= 38'(w_ax) * 38'(w_ax);
            r_a5_sy  <= 38'(w_ay) * 38'(w_ay);
            r_a6_n   <= r_a5_sx + r_a5_sy;
        end
    end

    // floor square root, one result bit per stage
    logic [37:0] r_sq_n [QSQ_STEPS];
    logic [37:0] r_sq_r [QSQ_STEPS];

    for (genvar i = 0; i < QSQ_STEPS; i++) begin : g_sqrt
        localparam logic [37:0] BIT = 38'd1 << (36 - 2 * i);
        logic [37:0] w_n;
        logic [37:0] w_r;
        logic [37:0] w_rb;

        if (i == 0) begin : g_first
            assign w_n = r_a6_n;
            assign w_r = '0;
        end else begin : g_next
            assign w_n = r_sq_n[i-1];
            assign w_r = r_sq_r[i-1];
        end
        assign w_rb = w_r + BIT;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (w_n >= w_rb) begin
                    r_sq_n[i] <= w_n - w_rb;
                    r_sq_r[i] <= (w_r >> 1) + BIT;
                end else begin
                    r_sq_n[i] <= w_n;
                    r_sq_r[i] <= w_r >> 1;
                end
            end
        end
    end

    // rotation angle t = |p|
    logic [18:0] w_t;
    logic signed [TRIG_W-1:0] w_sin_t;
    logic signed [TRIG_W-1:0] w_cos_t;

    assign w_t = r_sq_r[QSQ_STEPS-1][18:0];

    ptw_sin u_sin_t (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle ($signed({2'b00, w_t})),
        .o_sin   (w_sin_t)
    );

    ptw_sin u_cos_t (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle ($signed({2'b00, w_t}) + $signed({4'b0000, HALF_PI_Q16})),
        .o_sin   (w_cos_t)
    );

    // p waits for its trig values
    logic signed [P_W-1:0] r_pxd [PXY_DLY];
    logic signed [P_W-1:0] r_pyd [PXY_DLY];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pxd[0] <= r_a4_px;
            r_pyd[0] <= r_a4_py;
            for (int i = 1; i < PXY_DLY; i++) begin
                r_pxd[i] <= r_pxd[i-1];
                r_pyd[i] <= r_pyd[i-1];
            end
        end
    end

    // rotate p by t, products floored to Q16
    logic signed [37:0] r_r1_pc;
    logic signed [37:0] r_r1_ps;
    logic signed [37:0] r_r1_qc;
    logic signed [37:0] r_r1_qs;
    logic signed [38:0] w_dx;
    logic signed [38:0] w_dy;
    logic signed [P_W-1:0] r_r2_rx;
    logic signed [P_W-1:0] r_r2_ry;

    assign w_dx = 39'(r_r1_pc) - 39'(r_r1_ps);
    assign w_dy = 39'(r_r1_qc) + 39'(r_r1_qs);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_r1_pc <= r_pxd[PXY_DLY-1] * w_cos_t;
            r_r1_ps <= r_pyd[PXY_DLY-1] * w_sin_t;
            r_r1_qc <= r_pyd[PXY_DLY-1] * w_cos_t;
            r_r1_qs <= r_pxd[PXY_DLY-1] * w_sin_t;
            r_r2_rx <= sat_p(40'(w_dx >>> 16));
            r_r2_ry <= sat_p(40'(w_dy >>> 16));
        end
    end

    // ux from sin(rx), uy from cos(ry)
    logic signed [TRIG_W-1:0] w_sin_u;
    logic signed [TRIG_W-1:0] w_cos_u;

    ptw_sin u_sin_u (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANG_W'(r_r2_rx)),
        .o_sin   (w_sin_u)
    );

    ptw_sin u_cos_u (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_angle (ANG_W'(r_r2_ry) + $signed({4'b0000, HALF_PI_Q16})),
        .o_sin   (w_cos_u)
    );

    // texture coordinate: (|u| * (size - 1) >> 16) mod 255 by byte folding
    logic signed [33:0] w_ux;
    logic signed [33:0] w_uy;
    logic [32:0] r_t1_ax;
    logic [32:0] r_t1_ay;
    logic [42:0] r_t2_sx;
    logic [42:0] r_t2_sy;
    logic [9:0]  r_t3_bx;
    logic [9:0]  r_t3_by;
    logic [8:0]  w_fx;
    logic [8:0]  w_fy;
    logic [7:0]  r_t4_tx;
    logic [7:0]  r_t4_ty;
    logic [18:0] w_taddr;
    logic [15:0] r_t5_addr;

    assign w_ux = 34'(w_sin_u) + $signed({2'b00, r_phase});
    assign w_uy = 34'(w_cos_u) + $signed({2'b00, r_phase});
    assign w_fx = 9'(r_t3_bx[7:0]) + 9'(r_t3_bx[9:8]);
    assign w_fy = 9'(r_t3_by[7:0]) + 9'(r_t3_by[9:8]);
    assign w_taddr = 19'(r_t4_tx) + 19'(r_t4_ty) * TEX_W19;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1_ax <= w_ux[33] ? 33'(-w_ux) : 33'(w_ux);
            r_t1_ay <= w_uy[33] ? 33'(-w_uy) : 33'(w_uy);
            r_t2_sx <= 43'(r_t1_ax) * 43'(TSCALE_X);
            r_t2_sy <= 43'(r_t1_ay) * 43'(TSCALE_Y);
            r_t3_bx <= 10'(r_t2_sx[23:16]) + 10'(r_t2_sx[31:24])
                     + 10'(r_t2_sx[39:32]) + 10'(r_t2_sx[42:40]);
            r_t3_by <= 10'(r_t2_sy[23:16]) + 10'(r_t2_sy[31:24])
                     + 10'(r_t2_sy[39:32]) + 10'(r_t2_sy[42:40]);
            r_t4_tx <= (w_fx >= 9'd255) ? 8'(w_fx - 9'd255) : w_fx[7:0];
            r_t4_ty <= (w_fy >= 9'd255) ? 8'(w_fy - 9'd255) : w_fy[7:0];
            r_t5_addr <= w_taddr[15:0];
        end
    end

    // texture memory: one access per cycle while the pipeline advances, writes and reads in transaction order
    logic [31:0] r_tex_mem [65536];
    logic [31:0] r_m_data;
    logic        r_m_vld;
    logic        w_mem_wr;

    assign w_mem_wr = r_vld[TAG_DEPTH-1] && (r_tag[TAG_DEPTH-1].kind == KIND_WRITE);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (w_mem_wr) begin
                r_tex_mem[r_tag[TAG_DEPTH-1].addr] <= r_tag[TAG_DEPTH-1].texel;
            end else begin
                r_m_data <= r_tex_mem[r_t5_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_vld <= 1'b0;
        end else if (w_en) begin
            r_m_vld <= r_vld[TAG_DEPTH-1] && (r_tag[TAG_DEPTH-1].kind == KIND_PIXEL);
        end
    end

    // two-entry output buffer
    logic [31:0] r_ob0;
    logic [31:0] r_ob1;
    logic        w_push;
    logic        w_pop;

    assign w_push = w_en & r_m_vld;
    assign w_pop  = m_axis_tvalid & m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ob_cnt <= '0;
        end else begin
            case ({w_push, w_pop})
                2'b10:   r_ob_cnt <= r_ob_cnt + 2'd1;
                2'b01:   r_ob_cnt <= r_ob_cnt - 2'd1;
                default: r_ob_cnt <= r_ob_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case ({w_push, w_pop})
            2'b10: begin
                if (r_ob_cnt == 2'd0) begin
                    r_ob0 <= r_m_data;
                end else begin
                    r_ob1 <= r_m_data;
                end
            end
            2'b01:   r_ob0 <= r_ob1;
            2'b11:   r_ob0 <= r_m_data;
            default: ;
        endcase
    end

    assign m_axis_tvalid = (r_ob_cnt != 2'd0);
    assign m_axis_tdata  = r_ob0;

`ifndef SYNTH
    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_ob_cnt != OB_FULL))
        else $error("result pushed into a full output buffer");

    a_result_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && (r_ob_cnt == 2'd0)) |=> m_axis_tvalid)
        else $error("pixel result lost at the output buffer");

    a_stall_only_on_backlog: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (m_axis_tvalid && (r_ob_cnt == OB_FULL)))
        else $error("input stalled without an output backlog");
`endif

endmodule

@@ src/ptw_sin.sv @@
`timescale 1ns / 1ps
module ptw_sin import ptw_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [ANG_W-1:0]  i_angle,
    output logic signed [TRIG_W-1:0] o_sin
);

    // range reduction into [0, 2pi)
    logic signed [ANG_W-1:0] w_red;
    logic [18:0]             r1_r;

    always_comb begin
        if (i_angle < 0) begin
            w_red = i_angle + $signed({2'b00, TWO_PI_Q16});
        end else if (i_angle >= $signed({2'b00, TWO_PI_Q16})) begin
            w_red = i_angle - $signed({2'b00, TWO_PI_Q16});
        end else begin
            w_red = i_angle;
        end
    end

    // quadrant fold
    logic [18:0] w_f0;
    logic        w_odd;
    logic        w_neg;
    logic [16:0] w_f;
    logic [16:0] r2_f;
    logic        r2_neg;

    always_comb begin
        if (r1_r >= QUAD3_Q16) begin
            w_f0 = r1_r - QUAD3_Q16; w_odd = 1'b1; w_neg = 1'b1;
        end else if (r1_r >= QUAD2_Q16) begin
            w_f0 = r1_r - QUAD2_Q16; w_odd = 1'b0; w_neg = 1'b1;
        end else if (r1_r >= QUAD1_Q16) begin
            w_f0 = r1_r - QUAD1_Q16; w_odd = 1'b1; w_neg = 1'b0;
        end else begin
            w_f0 = r1_r;             w_odd = 1'b0; w_neg = 1'b0;
        end
        w_f = w_odd ? (HALF_PI_Q16 - w_f0[16:0]) : w_f0[16:0];
    end

    // x in Q30 and its square
    logic [30:0] w_x;
    logic [61:0] w_xx;
    t_sin_carry  r3_c;

    assign w_x  = {r2_f, 14'd0};
    assign w_xx = 62'(w_x) * 62'(w_x);

    // first divide: x2 / 72
    logic [63:0] w_p4;
    logic [31:0] r4_q0;
    t_sin_carry  r4_c;
    logic [31:0] w_rem5;
    logic [31:0] w_q5;
    logic [30:0] r5_t;
    t_sin_carry  r5_c;

    assign w_p4   = 64'(r3_c.x2) * 64'(RECIP_FIRST);
    assign w_rem5 = r4_c.x2 - 32'(r4_q0 * 32'(DIV_FIRST));
    assign w_q5   = r4_q0 + 32'(w_rem5 >= 32'(DIV_FIRST));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r    <= w_red[18:0];
            r2_f    <= w_f;
            r2_neg  <= w_neg;
            r3_c.x  <= w_x;
            r3_c.x2 <= w_xx[61:30];
            r3_c.neg <= r2_neg;
            r4_q0   <= w_p4[63:32];
            r4_c    <= r3_c;
            r5_t    <= Q30_ONE - w_q5[30:0];
            r5_c    <= r4_c;
        end
    end

    // horner steps: t = 1 - (x2 * t) / d
    logic [30:0] w_t_in [HORNER_STEPS];
    t_sin_carry  w_c_in [HORNER_STEPS];
    logic [31:0] r_ha_p  [HORNER_STEPS];
    t_sin_carry  r_ha_c  [HORNER_STEPS];
    logic [31:0] r_hb_p  [HORNER_STEPS];
    logic [31:0] r_hb_q0 [HORNER_STEPS];
    t_sin_carry  r_hb_c  [HORNER_STEPS];
    logic [30:0] r_hc_t  [HORNER_STEPS];
    t_sin_carry  r_hc_c  [HORNER_STEPS];

    for (genvar k = 0; k < HORNER_STEPS; k++) begin : g_horner
        logic [63:0] w_pa;
        logic [63:0] w_pb;
        logic [31:0] w_rem;
        logic [31:0] w_q;

        if (k == 0) begin : g_first
            assign w_t_in[k] = r5_t;
            assign w_c_in[k] = r5_c;
        end else begin : g_next
            assign w_t_in[k] = r_hc_t[k-1];
            assign w_c_in[k] = r_hc_c[k-1];
        end

        assign w_pa  = 64'(w_c_in[k].x2) * 64'(w_t_in[k]);
        assign w_pb  = 64'(r_ha_p[k]) * 64'(horner_recip(k));
        assign w_rem = r_hb_p[k] - 32'(r_hb_q0[k] * 32'(horner_div(k)));
        assign w_q   = r_hb_q0[k] + 32'(w_rem >= 32'(horner_div(k)));

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ha_p[k]  <= w_pa[61:30];
                r_ha_c[k]  <= w_c_in[k];
                r_hb_p[k]  <= r_ha_p[k];
                r_hb_q0[k] <= w_pb[63:32];
                r_hb_c[k]  <= r_ha_c[k];
                r_hc_t[k]  <= Q30_ONE - w_q[30:0];
                r_hc_c[k]  <= r_hb_c[k];
            end
        end
    end

    // s = x * t, then round to Q16 and apply the quadrant sign
    logic [61:0] w_s;
    logic [31:0] r_s;
    logic        r_s_neg;
    logic [32:0] w_rnd;
    logic signed [TRIG_W-1:0] w_mag;
    logic signed [TRIG_W-1:0] r_out;

    assign w_s   = 62'(r_hc_c[HORNER_STEPS-1].x) * 62'(r_hc_t[HORNER_STEPS-1]);
    assign w_rnd = 33'(r_s) + 33'd8192;
    assign w_mag = $signed(w_rnd[32:14]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s     <= w_s[61:30];
            r_s_neg <= r_hc_c[HORNER_STEPS-1].neg;
            r_out   <= r_s_neg ? -w_mag : w_mag;
        end
    end

    assign o_sin = r_out;

endmodule
